>>> hdl/psai_pkg.sv
// Package for the pack size to adjustment interpolator: breakpoint tables,
// reciprocal constants and the word types passed between the front, queue and back.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package psai_pkg;

    // Breakpoint table
    localparam int NUM_POINTS = 6;
    localparam int NUM_SEGS   = NUM_POINTS - 1;

    localparam logic [15:0] BP_SIZE [0:NUM_POINTS-1] = '{
        16'd100, 16'd200, 16'd500, 16'd1000, 16'd2000, 16'd3000
    };
    localparam logic [5:0] BP_CODE [0:NUM_POINTS-1] = '{
        6'h08, 6'h0B, 6'h10, 6'h19, 6'h2D, 6'h36
    };

    // Division by a segment span is a multiply by ceil(2^RECIP_SHIFT / span).
    // The shift is large enough that the truncated quotient is exact for every
    // product that a segment can produce (below 2^15).
    localparam int RECIP_SHIFT = 25;
    localparam logic [18:0] SEG_RECIP [0:NUM_SEGS-1] = '{
        19'd335545,   // span 100
        19'd111849,   // span 300
        19'd67109,    // span 500
        19'd33555,    // span 1000
        19'd33555     // span 1000
    };

    // Widths of the intermediate values
    localparam int OFF_W   = 10;   // offset into a segment, up to 1000
    localparam int RISE_W  = 5;    // code rise over a segment, up to 20
    localparam int PROD1_W = OFF_W + RISE_W;
    localparam int PROD2_W = PROD1_W + 19;
    localparam int QUOT_W  = 5;    // quotient never exceeds the rise

    // Classified word from the front to the back
    typedef struct packed {
        logic              in_range;
        logic [5:0]        code_lo;
        logic [RISE_W-1:0] rise;
        logic [OFF_W-1:0]  offset;
        logic [18:0]       recip;
    } t_job;

    // Finished result word
    typedef struct packed {
        logic [5:0] adjust_code;
        logic       in_range;
    } t_result;

    // Queue status toward its neighbors
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

`default_nettype wire

>>> hdl/psai_front.sv
// Front part: accepts a capacity word, finds its segment and registers the job.
// Depends on psai_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psai_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [15:0]      i_pack_capacity,
    output logic                  o_full,
    output psai_pkg::t_job        o_job,
    output logic                  o_job_valid,
    input  wire logic             i_queue_full
);

    logic                         r_valid;
    psai_pkg::t_job               r_job;
    psai_pkg::t_job               n_job;
    logic [2:0]                   seg;
    logic [2:0]                   seg_hi;
    logic                         in_range;
    logic [15:0]                  diff;
    logic                         advance;

    // Pick the segment whose lower breakpoint is the last one not above the capacity
    always_comb begin
        seg = 3'd0;
        for (int i = 1; i < psai_pkg::NUM_SEGS; i++) begin
            if (i_pack_capacity >= psai_pkg::BP_SIZE[i]) begin
                seg = 3'(i);
            end
        end
        seg_hi   = seg + 3'd1;
        in_range = (i_pack_capacity >= psai_pkg::BP_SIZE[0]) &&
                   (i_pack_capacity <= psai_pkg::BP_SIZE[psai_pkg::NUM_POINTS-1]);
        diff     = i_pack_capacity - psai_pkg::BP_SIZE[seg];
    end

    // Build the job; out of range yields a zero code through zero terms
    always_comb begin
        n_job = '0;
        if (in_range) begin
            n_job.in_range = 1'b1;
            n_job.code_lo  = psai_pkg::BP_CODE[seg];
            n_job.rise     = psai_pkg::RISE_W'(psai_pkg::BP_CODE[seg_hi]
                                               - psai_pkg::BP_CODE[seg]);
            n_job.offset   = diff[psai_pkg::OFF_W-1:0];
            n_job.recip    = psai_pkg::SEG_RECIP[seg];
        end
    end

    // Hold the job until the queue takes it
    assign advance = !r_valid || !i_queue_full;
    assign o_full  = !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_push) begin
            r_job <= n_job;
        end
    end

    assign o_job       = r_job;
    assign o_job_valid = r_valid;

endmodule

`default_nettype wire

>>> hdl/psai_queue.sv
// Short queue of classified words between the front and the back.
// Depends on psai_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psai_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  psai_pkg::t_job        i_wr_data,
    input  wire logic             i_rd,
    output psai_pkg::t_job        o_rd_data,
    output psai_pkg::t_queue_status o_status
);

    psai_pkg::t_job               r_mem [0:3];
    logic [1:0]                   r_wr_ptr;
    logic [1:0]                   r_rd_ptr;
    logic [2:0]                   r_count;
    logic                         do_wr;
    logic                         do_rd;

    assign o_status.full  = (r_count == 3'd4);
    assign o_status.empty = (r_count == 3'd0);
    assign do_wr = i_wr && !o_status.full;
    assign do_rd = i_rd && !o_status.empty;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= r_wr_ptr + 2'd1;
            end
            if (do_rd) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 3'd1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 3'd1;
            end
        end
    end

    // Store the word
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

>>> hdl/psai_back.sv
// Back part: two multiply stages for the interpolation and the result queue.
// Depends on psai_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psai_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  psai_pkg::t_job        i_job,
    input  psai_pkg::t_queue_status i_queue_status,
    output logic                  o_queue_rd,
    output logic                  empty,
    input  wire logic             pop,
    output logic [5:0]            o_adjust_code,
    output logic                  o_in_range
);

    // Multiply pipeline
    logic                         r_v1;
    logic                         r_v2;
    logic [psai_pkg::PROD1_W-1:0] r_prod1;
    logic [18:0]                  r_recip1;
    logic [5:0]                   r_code_lo1;
    logic                         r_ok1;
    logic [psai_pkg::PROD2_W-1:0] r_prod2;
    logic [5:0]                   r_code_lo2;
    logic                         r_ok2;

    // Result queue
    psai_pkg::t_result            r_out_mem [0:3];
    logic [1:0]                   r_out_wr_ptr;
    logic [1:0]                   r_out_rd_ptr;
    logic [2:0]                   r_out_count;
    psai_pkg::t_result            n_result;
    logic [2:0]                   committed;
    logic                         out_rd;
    logic [psai_pkg::QUOT_W-1:0]  quot;

    // Take a word only when the result queue has room for everything in flight
    assign committed  = r_out_count + {2'd0, r_v1} + {2'd0, r_v2};
    assign o_queue_rd = !i_queue_status.empty && (committed < 3'd4);

    // Pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= o_queue_rd;
            r_v2 <= r_v1;
        end
    end

    // Stage one: rise times offset
    always_ff @(posedge i_clk) begin
        r_prod1    <= {{psai_pkg::OFF_W{1'b0}}, i_job.rise}
                    * {{psai_pkg::RISE_W{1'b0}}, i_job.offset};
        r_recip1   <= i_job.recip;
        r_code_lo1 <= i_job.code_lo;
        r_ok1      <= i_job.in_range;
    end

    // Stage two: divide by the span through its reciprocal
    always_ff @(posedge i_clk) begin
        r_prod2    <= {19'd0, r_prod1} * {{psai_pkg::PROD1_W{1'b0}}, r_recip1};
        r_code_lo2 <= r_code_lo1;
        r_ok2      <= r_ok1;
    end

    assign quot = r_prod2[psai_pkg::RECIP_SHIFT +: psai_pkg::QUOT_W];

    always_comb begin
        n_result.adjust_code = r_code_lo2 + {1'b0, quot};
        n_result.in_range    = r_ok2;
    end

    // Result queue pointers and count
    assign out_rd = pop && !empty;
    assign empty  = (r_out_count == 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_wr_ptr <= 2'd0;
            r_out_rd_ptr <= 2'd0;
            r_out_count  <= 3'd0;
        end else begin
            if (r_v2) begin
                r_out_wr_ptr <= r_out_wr_ptr + 2'd1;
            end
            if (out_rd) begin
                r_out_rd_ptr <= r_out_rd_ptr + 2'd1;
            end
            if (r_v2 && !out_rd) begin
                r_out_count <= r_out_count + 3'd1;
            end else if (out_rd && !r_v2) begin
                r_out_count <= r_out_count - 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v2) begin
            r_out_mem[r_out_wr_ptr] <= n_result;
        end
    end

    assign o_adjust_code = r_out_mem[r_out_rd_ptr].adjust_code;
    assign o_in_range    = r_out_mem[r_out_rd_ptr].in_range;

endmodule

`default_nettype wire

>>> hdl/pack_size_to_adjustment_interp.sv
// Top level of the pack size to adjustment interpolator.
// Depends on psai_pkg, psai_front, psai_queue and psai_back.
//
// Channel   Direction  Handshake        Words
// input     in         push / full      i_pack_capacity
// result    out        empty / pop      o_adjust_code, o_in_range
//
// One capacity word is taken per cycle while full is low. Its result reaches the result
// ports through the front register, the queue, the two multiply stages and the result queue.
// The rate is set by the two-stage reciprocal multiply, which takes a word each cycle
// while the result queue has room for everything in flight.
// Synchronous active-low reset empties both queues and the pipeline.
// A stalled pop fills the result queue, then the middle queue, then raises full.
`timescale 1ns / 1ps
`default_nettype none

module pack_size_to_adjustment_interp (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [15:0] i_pack_capacity,
    output logic             empty,
    input  wire logic        pop,
    output logic [5:0]       o_adjust_code,
    output logic             o_in_range
);

    psai_pkg::t_job          front_job;
    logic                    front_valid;
    psai_pkg::t_job          queue_job;
    psai_pkg::t_queue_status queue_status;
    logic                    queue_rd;

    // Classify incoming words
    psai_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_pack_capacity (i_pack_capacity),
        .o_full          (full),
        .o_job           (front_job),
        .o_job_valid     (front_valid),
        .i_queue_full    (queue_status.full)
    );

    // Decouple front and back
    psai_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (front_valid),
        .i_wr_data (front_job),
        .i_rd      (queue_rd),
        .o_rd_data (queue_job),
        .o_status  (queue_status)
    );

    // Interpolate and deliver
    psai_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job          (queue_job),
        .i_queue_status (queue_status),
        .o_queue_rd     (queue_rd),
        .empty          (empty),
        .pop            (pop),
        .o_adjust_code  (o_adjust_code),
        .o_in_range     (o_in_range)
    );

endmodule

`default_nettype wire
